// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge with an
// active-low reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Types, widths and helpers shared by the sorted record table and its checker.
// ----------------------------------------------------------------------------
package srt_pkg;

    // Table geometry
    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int VOL_W   = 16;
    localparam int PRICE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic [KEY_W-1:0]   name;
        logic [VOL_W-1:0]   volume;
        logic [PRICE_W-1:0] price;
    } t_record;

    localparam int REC_W = $bits(t_record);

    // Stored entry must stay ahead of a new record with this key and volume
    function automatic logic stays_before(t_record e, logic [KEY_W-1:0] key,
                                          logic [VOL_W-1:0] vol);
        if (e.name != key) begin
            return e.name < key;
        end
        return e.volume <= vol;
    endfunction

endpackage

// ===== design/srt_ram.sv =====
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/sorted_record_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table_core: records kept sorted by name key, then volume.
// Clear, a read past the count, an insert into a full table and a remove on
// an empty table finish without a RAM access; a read takes one RAM access,
// remove and insert one RAM access per entry.
// One word at a time; start is taken again in the cycle o_done is shown.
// Synchronous reset empties the table; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_record_table_core
    import srt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [OP_W-1:0]    i_op,
    input  logic [KEY_W-1:0]   i_name_key,
    input  logic [VOL_W-1:0]   i_volume,
    input  logic [PRICE_W-1:0] i_price_bits,
    input  logic [POS_W-1:0]   i_position,
    output logic               busy,
    output logic               o_done,
    output logic               o_ok,
    output logic [KEY_W-1:0]   o_out_name,
    output logic [VOL_W-1:0]   o_out_volume,
    output logic [PRICE_W-1:0] o_out_price,
    output logic [COUNT_W-1:0] o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS,
        S_INS_LAST,
        S_REM_RD,
        S_REM,
        S_RD_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_found, n_found;
    t_record            r_new, n_new;
    logic               r_done, n_done;
    logic               r_ok, n_ok;
    logic [KEY_W-1:0]   r_out_name, n_out_name;
    logic [VOL_W-1:0]   r_out_volume, n_out_volume;
    logic [PRICE_W-1:0] r_out_price, n_out_price;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    // RAM port signals
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    t_record            wr_data;
    logic [REC_W-1:0]   ram_rd_data;
    t_record            rd_rec;
    logic               found_now;

    assign rd_rec = t_record'(ram_rd_data);

    srt_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer: insert walks down from the top shifting entries up,
    // remove walks up from the bottom shifting entries down after the hit.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_found      = r_found;
        n_new        = r_new;
        n_done       = 1'b0;
        n_ok         = 1'b0;
        n_out_name   = '0;
        n_out_volume = '0;
        n_out_price  = '0;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_new;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        found_now    = r_found || (rd_rec.name == r_new.name);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_new.name   = i_name_key;
                    n_new.volume = i_volume;
                    n_new.price  = i_price_bits;
                    n_found      = 1'b0;
                    case (t_op'(i_op))
                        OP_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_done = 1'b1;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_INS_LAST;
                            end else begin
                                n_idx   = IDX_W'(r_count - CNT_W'(1));
                                n_state = S_INS_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_REM_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                            n_done  = 1'b1;
                        end
                        OP_READ: begin
                            if (CNT_W'(i_position) < r_count) begin
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(i_position);
                                n_state = S_RD_OUT;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end

            S_INS_RD: begin
                rd_en   = 1'b1;
                n_state = S_INS;
            end

            // rd_rec holds entry r_idx; it either stays or moves up one
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + IDX_W'(1);
                if (stays_before(rd_rec, r_new.name, r_new.volume)) begin
                    wr_data = r_new;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wr_data = rd_rec;
                    if (r_idx == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - IDX_W'(1);
                        n_idx   = r_idx - IDX_W'(1);
                    end
                end
            end

            S_INS_LAST: begin
                wr_en   = 1'b1;
                wr_data = r_new;
                n_count = r_count + CNT_W'(1);
                n_ok    = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_REM_RD: begin
                rd_en   = 1'b1;
                n_state = S_REM;
            end

            // rd_rec holds entry r_idx; past the hit it moves down one
            S_REM: begin
                n_found = found_now;
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx - IDX_W'(1);
                    wr_data = rd_rec;
                end
                if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_count = r_count - CNT_W'(found_now);
                    n_ok    = found_now;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                    n_idx   = r_idx + IDX_W'(1);
                end
            end

            S_RD_OUT: begin
                n_ok         = 1'b1;
                n_out_name   = rd_rec.name;
                n_out_volume = rd_rec.volume;
                n_out_price  = rd_rec.price;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        n_out_count = COUNT_W'(n_count);
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_new        <= n_new;
        r_ok         <= n_ok;
        r_out_name   <= n_out_name;
        r_out_volume <= n_out_volume;
        r_out_price  <= n_out_price;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_out_name    = r_out_name;
    assign o_out_volume  = r_out_volume;
    assign o_out_price   = r_out_price;
    assign o_entry_count = r_out_count;

endmodule

// ===== design/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks on the sorted record table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srt_checker
    import srt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic               o_ok,
    input logic [KEY_W-1:0]   o_out_name,
    input logic [VOL_W-1:0]   o_out_volume,
    input logic [PRICE_W-1:0] o_out_price,
    input logic [COUNT_W-1:0] o_entry_count
);

    // Count never exceeds the table size
    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_done, o_entry_count <= COUNT_W'(DEPTH), "count above depth")

    // An accepted word either finishes at once or keeps the block busy
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted word lost")

    // Busy drops only when a result is shown
    `ASSERT_SAME(a_busy_ends_done, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_done, "busy ended without result")

    // Failed operations return zero record fields
    `ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_done && !o_ok, (o_out_name == '0) && (o_out_volume == '0) && (o_out_price == '0), "failed op with data")

endmodule

bind sorted_record_table_core srt_checker u_srt_checker (.*);

// ===== test/sorted_record_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table_core_tb
// Self-checking bench for the sorted record table. A queue of command words
// (insert, remove, clear, read) is built up front, then a driver hands them
// to the core through the start/busy handshake with random idle bursts. A
// monitor keeps a shadow copy of the table, predicts each reply as its
// command is taken, and checks every o_done strobe against the oldest one.
// ----------------------------------------------------------------------------
module sorted_record_table_core_tb
    import srt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 850;
    localparam int TAIL_WORDS   = 100;      // no idling this close to the end
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [VOL_W-1:0]   vol;
        logic [PRICE_W-1:0] price;
        logic [POS_W-1:0]   pos;
    } t_table_cmd;

    typedef struct {
        logic               ok;
        logic [KEY_W-1:0]   name;
        logic [VOL_W-1:0]   vol;
        logic [PRICE_W-1:0] price;
        logic [COUNT_W-1:0] count;
    } t_table_reply;

    // DUT inputs, known from time zero
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic [OP_W-1:0]    i_op         = '0;
    logic [KEY_W-1:0]   i_name_key   = '0;
    logic [VOL_W-1:0]   i_volume     = '0;
    logic [PRICE_W-1:0] i_price_bits = '0;
    logic [POS_W-1:0]   i_position   = '0;

    logic               busy;
    logic               o_done;
    logic               o_ok;
    logic [KEY_W-1:0]   o_out_name;
    logic [VOL_W-1:0]   o_out_volume;
    logic [PRICE_W-1:0] o_out_price;
    logic [COUNT_W-1:0] o_entry_count;

    sorted_record_table_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_op          (i_op),
        .i_name_key    (i_name_key),
        .i_volume      (i_volume),
        .i_price_bits  (i_price_bits),
        .i_position    (i_position),
        .busy          (busy),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_out_name    (o_out_name),
        .o_out_volume  (o_out_volume),
        .o_out_price   (o_out_price),
        .o_entry_count (o_entry_count)
    );

    // Bench state
    t_table_cmd   cmd_q[$];
    t_table_reply reply_q[$];
    int           words_queued  = 0;
    int           words_taken   = 0;
    int           mismatch_cnt  = 0;
    int           cycle_cnt     = 0;
    int           gap_left      = 0;
    logic         taken         = 1'b0;
    logic [KEY_W-1:0] key_pool[8];

    // Shadow copy of the table
    logic [KEY_W-1:0]   shadow_name[DEPTH];
    logic [VOL_W-1:0]   shadow_vol[DEPTH];
    logic [PRICE_W-1:0] shadow_price[DEPTH];
    int                 shadow_count = 0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the shadow table and return the reply it gives
    function automatic t_table_reply apply_to_shadow(t_table_cmd c);
        t_table_reply r;
        int slot;
        r = '{ok: 1'b0, name: '0, vol: '0, price: '0, count: '0};
        slot = 0;
        case (c.op)
            OP_INSERT: begin
                if (shadow_count < DEPTH) begin
                    // skip entries with a lower key, or equal key and volume <= new
                    while (slot < shadow_count &&
                           ((shadow_name[slot] != c.key) ? (shadow_name[slot] < c.key)
                                                        : (shadow_vol[slot] <= c.vol)))
                        slot++;
                    for (int i = shadow_count; i > slot; i--) begin
                        shadow_name[i]  = shadow_name[i-1];
                        shadow_vol[i]   = shadow_vol[i-1];
                        shadow_price[i] = shadow_price[i-1];
                    end
                    shadow_name[slot]  = c.key;
                    shadow_vol[slot]   = c.vol;
                    shadow_price[slot] = c.price;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                // name only; volume and price play no part
                while (slot < shadow_count && shadow_name[slot] != c.key)
                    slot++;
                if (slot < shadow_count) begin
                    for (int i = slot + 1; i < shadow_count; i++) begin
                        shadow_name[i-1]  = shadow_name[i];
                        shadow_vol[i-1]   = shadow_vol[i];
                        shadow_price[i-1] = shadow_price[i];
                    end
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            default: begin
                if (int'(c.pos) < shadow_count) begin
                    r.name  = shadow_name[c.pos];
                    r.vol   = shadow_vol[c.pos];
                    r.price = shadow_price[c.pos];
                    r.ok    = 1'b1;
                end
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    task automatic push_cmd(t_op op, logic [KEY_W-1:0] key, logic [VOL_W-1:0] vol,
                            logic [PRICE_W-1:0] price, logic [POS_W-1:0] pos);
        cmd_q.push_back('{op: op, key: key, vol: vol, price: price, pos: pos});
        words_queued++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VOL_W-1:0] pick_vol();
        case ($urandom_range(0, 3))
            0:       return VOL_W'($urandom_range(0, 3));
            1:       return {VOL_W{1'b1}};
            default: return VOL_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 1) == 0)
            return POS_W'($urandom_range(0, 7));
        return POS_W'($urandom);
    endfunction

    // Random word with every field filled, op chosen by the caller
    task automatic push_random(t_op op);
        push_cmd(op, pick_key(), pick_vol(), $urandom, pick_pos());
    endtask

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what,
                     exp_v, act_v);
    endtask

    // Driver: present the next word once the current one is taken
    always @(negedge i_clk) begin : drive
        t_table_cmd w;
        if (i_rst_n && (!start || taken)) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_q.size() != 0) begin
                w = cmd_q.pop_front();
                start        <= 1'b1;
                i_op         <= w.op;
                i_name_key   <= w.key;
                i_volume     <= w.vol;
                i_price_bits <= w.price;
                i_position   <= w.pos;
                if (cmd_q.size() >= TAIL_WORDS && $urandom_range(0, 5) == 0)
                    gap_left <= $urandom_range(1, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check the strobed reply, then predict for a newly taken word
    always @(posedge i_clk) begin : watch
        t_table_reply exp_r;
        t_table_cmd   c;
        if (i_rst_n) begin
            if (o_done) begin
                if (reply_q.size() == 0) begin
                    report("unexpected reply, count", '0, 64'(o_entry_count));
                end else begin
                    exp_r = reply_q.pop_front();
                    if (o_ok !== exp_r.ok)
                        report("ok", 64'(exp_r.ok), 64'(o_ok));
                    if (o_out_name !== exp_r.name)
                        report("name", exp_r.name, o_out_name);
                    if (o_out_volume !== exp_r.vol)
                        report("volume", 64'(exp_r.vol), 64'(o_out_volume));
                    if (o_out_price !== exp_r.price)
                        report("price", 64'(exp_r.price), 64'(o_out_price));
                    if (o_entry_count !== exp_r.count)
                        report("count", 64'(exp_r.count), 64'(o_entry_count));
                end
            end
            if (start && busy === 1'b0) begin
                c.op    = t_op'(i_op);
                c.key   = i_name_key;
                c.vol   = i_volume;
                c.price = i_price_bits;
                c.pos   = i_position;
                reply_q.push_back(apply_to_shadow(c));
                words_taken++;
            end
            taken <= start && busy === 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("sorted_record_table_core_tb: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : stim
        logic [KEY_W-1:0] alpha;
        int mode;
        int n;
        int pick;

        for (int i = 0; i < DEPTH; i++) begin
            shadow_name[i]  = '0;
            shadow_vol[i]   = '0;
            shadow_price[i] = '0;
        end
        alpha = 64'h414C504841000000;   // "ALPHA"
        key_pool[0] = '0;
        key_pool[1] = {KEY_W{1'b1}};
        key_pool[2] = alpha;
        key_pool[3] = {alpha[63:8], 8'h01};
        for (int i = 4; i < 8; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed words
        push_cmd(OP_READ,   '0, '0, '0, '0);                       // read on empty
        push_cmd(OP_REMOVE, alpha, '0, '0, '0);                    // remove on empty
        push_cmd(OP_INSERT, {KEY_W{1'b1}}, {VOL_W{1'b1}}, {PRICE_W{1'b1}}, '0);
        push_cmd(OP_INSERT, '0, '0, '0, {POS_W{1'b1}});
        push_cmd(OP_INSERT, alpha, 16'd100, 32'h0000_0001, '0);
        push_cmd(OP_INSERT, alpha, 16'd50, 32'h0000_0002, '0);     // equal key, lower vol
        push_cmd(OP_INSERT, alpha, 16'd100, 32'h0000_0003, '0);    // equal key and vol
        push_cmd(OP_INSERT, alpha, {VOL_W{1'b1}}, 32'hA5A5_5A5A, '0);
        push_cmd(OP_INSERT, {alpha[63:8], 8'h01}, '0, 32'h8000_0000, '0);
        for (int p = 0; p < 7; p++)
            push_cmd(OP_READ, {KEY_W{1'b1}}, {VOL_W{1'b1}}, {PRICE_W{1'b1}}, POS_W'(p));
        push_cmd(OP_READ,   '0, '0, '0, 5'd8);                     // past the count
        push_cmd(OP_READ,   '0, '0, '0, {POS_W{1'b1}});            // far past the count
        push_cmd(OP_REMOVE, alpha, 16'hFFFF, 32'hFFFF_FFFF, '0);   // first match only
        push_cmd(OP_READ,   '0, '0, '0, 5'd1);
        push_cmd(OP_REMOVE, 64'h1234_5678_9ABC_DEF0, '0, '0, '0);  // no match
        push_cmd(OP_CLEAR,  {KEY_W{1'b1}}, '0, '0, {POS_W{1'b1}});
        push_cmd(OP_READ,   '0, '0, '0, '0);                       // cleared, not scrubbed
        push_cmd(OP_INSERT, alpha, 16'd7, 32'hDEAD_BEEF, '0);
        push_cmd(OP_READ,   '0, '0, '0, '0);

        // Random rounds; the first one is a long fill round, mostly inserts
        mode = 0;
        while (words_queued < RANDOM_WORDS) begin
            case (mode)
                0: begin    // fill, then look around
                    n = $urandom_range(20, 45);
                    if (words_queued < 40) n = 45;
                    for (int i = 0; i < n; i++)
                        push_random(($urandom_range(0, 99) < 85) ? OP_INSERT : OP_READ);
                end
                1: begin    // drain by name
                    n = $urandom_range(10, 40);
                    for (int i = 0; i < n; i++)
                        push_random(($urandom_range(0, 99) < 70) ? OP_REMOVE : OP_READ);
                end
                2: begin    // mixed traffic
                    n = $urandom_range(10, 40);
                    for (int i = 0; i < n; i++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 40)      push_random(OP_INSERT);
                        else if (pick < 65) push_random(OP_REMOVE);
                        else if (pick < 95) push_random(OP_READ);
                        else                push_random(OP_CLEAR);
                    end
                end
                default: begin  // raw noise on every field
                    for (int i = 0; i < 10; i++)
                        push_cmd(t_op'($urandom_range(0, 3)), {$urandom, $urandom},
                                 VOL_W'($urandom), $urandom, POS_W'($urandom));
                end
            endcase
            mode = $urandom_range(0, 3);
        end

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_queued) @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && reply_q.size() == 0) begin
            $display("sorted_record_table_core_tb: PASS");
        end else begin
            $display("sorted_record_table_core_tb: FAIL");
        end
        $finish;
    end

endmodule
